>>> hw/rtl/gvn_pkg.sv
// gvn_pkg: shared types and constants of the grid vertex normal block.
// No dependencies; used by gvn_core and grid_vertex_normal_top.
package gvn_pkg;

    localparam int MAX_GRID_DEF = 64;
    localparam int GRID_W       = 7;
    localparam int POS_W        = 32;
    localparam int DIFF_W       = 33;
    localparam int NRM_W        = 16;
    localparam int ROWCOL_W     = 6;
    localparam int Q14_ONE      = 16384;
    localparam logic [GRID_W-1:0] GRID_RST = 7'd64;

    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [NRM_W-1:0]  nrm_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_RD_B,
        TS_RD_C,
        TS_CALC,
        TS_OUT
    } top_state_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_MUL,
        CS_MAX,
        CS_NORM_R,
        CS_NORM_L,
        CS_SQ,
        CS_SQRT,
        CS_DIV_LD,
        CS_DIV,
        CS_DONE
    } core_state_t;

    // handshake between the row sequencer and the arithmetic core
    typedef struct packed {
        logic start;
        logic done;
    } core_ctl_t;

endpackage

>>> hw/rtl/grid_vertex_normal_top.sv
// grid_vertex_normal_top: row sequencer, ping-pong line buffer and output register
// around gvn_core. Depends on gvn_pkg and gvn_core.
//
//  channel  dir  handshake            word
//  s_*      in   s_tvalid/s_tready    tdata pos_x,pos_y,pos_z; tuser first_of_grid
//  m_*      out  m_tvalid/m_tready    tdata normal_row,normal_col,norm_x,norm_y,norm_z
//  cfg_*    in   cfg_valid/cfg_ready  grid_size
//
// A word with no result leaves the sequencer idle; a last-column word goes straight to the
// output register. A full normal takes 32 square root steps and 3 x 15 divide steps through
// one shared subtractor, plus multiplier and scaling steps.
// Reset clears counters and control; line buffer contents stay undefined.
// s_tready is low while a word is in work; a stalled result holds the output register and the sequencer.
module grid_vertex_normal_top #(
    parameter int MAX_GRID = gvn_pkg::MAX_GRID_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,   // pos_x, pos_y, pos_z
    input  logic                        s_tuser,   // first_of_grid
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // normal_row, normal_col, norm_x,
                                                   // norm_y, norm_z, zero pad
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gvn_pkg::GRID_W-1:0]  cfg_data   // grid_size
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int AW = CW + 1;
    localparam int GW = ($clog2(MAX_GRID + 1) > gvn_pkg::GRID_W) ?
                        $clog2(MAX_GRID + 1) : gvn_pkg::GRID_W;
    localparam int PW = gvn_pkg::POS_W;

    gvn_pkg::top_state_t state_reg, state_next;
    logic [gvn_pkg::GRID_W-1:0] grid_reg;
    logic [CW-1:0]   row_reg, row_next, col_reg, col_next;
    logic            bank_reg, bank_next;
    logic [CW-1:0]   r_reg, c_reg;
    logic            pbank_reg, zero_reg;
    logic [3*PW-1:0] a_reg, b_reg;
    logic [3*PW-1:0] lbuf_mem [2*MAX_GRID];
    logic [3*PW-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            m_tvalid_reg;
    logic [63:0]     m_tdata_reg;

    logic            accept;
    logic [GW-1:0]   grid_ext, g_eff;
    logic [CW-1:0]   c_in, r_in;
    logic            last_col, emit;
    logic [CW-1:0]   row_m1;
    gvn_pkg::core_ctl_t    core_ctl;
    gvn_pkg::diff_t [5:0]  diff;
    gvn_pkg::nrm_t  [2:0]  core_norm;
    gvn_pkg::nrm_t  [2:0]  out_norm;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == gvn_pkg::TS_IDLE);

    assign grid_ext = GW'(grid_reg);
    assign g_eff    = (grid_ext < GW'(2)) ? GW'(2) :
                      ((grid_ext > GW'(MAX_GRID)) ? GW'(MAX_GRID) : grid_ext);
    assign c_in     = s_tuser ? '0 : col_reg;
    assign r_in     = s_tuser ? '0 : row_reg;
    assign last_col = (GW'(c_in) + GW'(1)) >= g_eff;
    assign emit     = (r_in != '0);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next  = '0;
                row_next  = ((GW'(r_in) + GW'(1)) >= g_eff) ? '0 : r_in + CW'(1);
                bank_next = ~bank_reg;
            end
            else
            begin
                col_next = c_in + CW'(1);
                row_next = r_in;
            end
        end
    end

    // previous row sits in the bank not being written
    always_comb
    begin
        if (state_reg == gvn_pkg::TS_IDLE)
            rd_addr = {~bank_reg, c_in};
        else
            rd_addr = {pbank_reg, c_reg + CW'(1)};
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = gvn_pkg::diff_t'($signed(a_reg[k*PW +: PW]))
                    - gvn_pkg::diff_t'($signed(b_reg[k*PW +: PW]));
            diff[k+3] = gvn_pkg::diff_t'($signed(b_reg[k*PW +: PW]))
                      - gvn_pkg::diff_t'($signed(rd_data_reg[k*PW +: PW]));
        end
    end

    assign core_ctl.start = (state_reg == gvn_pkg::TS_RD_C);

    gvn_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_ctl.start),
        .d     (diff),
        .done  (core_ctl.done),
        .norm  (core_norm)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gvn_pkg::TS_IDLE:
            begin
                if (accept && emit)
                    state_next = last_col ? gvn_pkg::TS_OUT : gvn_pkg::TS_RD_B;
            end
            gvn_pkg::TS_RD_B:
                state_next = gvn_pkg::TS_RD_C;
            gvn_pkg::TS_RD_C:
                state_next = gvn_pkg::TS_CALC;
            gvn_pkg::TS_CALC:
            begin
                if (core_ctl.done)
                    state_next = gvn_pkg::TS_OUT;
            end
            gvn_pkg::TS_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = gvn_pkg::TS_IDLE;
            end
            default:
                state_next = gvn_pkg::TS_IDLE;
        endcase
    end

    assign row_m1 = r_reg - CW'(1);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            out_norm[k] = zero_reg ? '0 : core_norm[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gvn_pkg::TS_IDLE;
            grid_reg     <= gvn_pkg::GRID_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            bank_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            bank_reg  <= bank_next;
            if (cfg_valid && cfg_ready)
                grid_reg <= cfg_data;
            if (state_reg == gvn_pkg::TS_OUT && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lbuf_mem[{bank_reg, c_in}] <= s_tdata;
            a_reg     <= s_tdata;
            r_reg     <= r_in;
            c_reg     <= c_in;
            pbank_reg <= ~bank_reg;
            zero_reg  <= last_col;
        end
        rd_data_reg <= lbuf_mem[rd_addr];
        if (state_reg == gvn_pkg::TS_RD_B)
            b_reg <= rd_data_reg;
        if (state_reg == gvn_pkg::TS_OUT && (!m_tvalid_reg || m_tready))
            m_tdata_reg <= {4'b0, out_norm[2], out_norm[1], out_norm[0],
                            gvn_pkg::ROWCOL_W'(c_reg), gvn_pkg::ROWCOL_W'(row_m1)};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // results only leave the core while the sequencer waits for them
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctl.done |-> state_reg == gvn_pkg::TS_CALC)
        else $error("core finished outside of calc state");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        GW'(col_reg) < GW'(MAX_GRID))
        else $error("column counter out of range");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            $signed(m_tdata[27:12]) >= -16'sd16384 && $signed(m_tdata[27:12]) <= 16'sd16384 &&
            $signed(m_tdata[43:28]) >= -16'sd16384 && $signed(m_tdata[43:28]) <= 16'sd16384 &&
            $signed(m_tdata[59:44]) >= -16'sd16384 && $signed(m_tdata[59:44]) <= 16'sd16384)
        else $error("normal component beyond unit range");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !emit |=> state_reg == gvn_pkg::TS_IDLE)
        else $error("first-row word started work");

endmodule

>>> hw/rtl/gvn_core.sv
// gvn_core: unit normal of two difference vectors, one shared multiplier and
// one shared trial subtractor under a sequencer (cross, scale, sqrt, divide).
// Depends on gvn_pkg.
module gvn_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  gvn_pkg::diff_t [5:0]     d,
    output logic                     done,
    output gvn_pkg::nrm_t  [2:0]     norm
);

    localparam int EW = 31;   // prescaled difference
    localparam int PW = 62;   // product
    localparam int NW = 63;   // cross product component
    localparam int MW = 62;   // magnitude of a component
    localparam int RW = 63;   // root / bit of the square root
    localparam int QW = 15;   // quotient bits
    localparam int DW = 45;   // dividend / shifted divisor
    localparam int LW = 31;   // vector length

    gvn_pkg::core_state_t state_reg, state_next;
    logic [4:0]           step_reg, step_next;
    logic [1:0]           comp_reg, comp_next;
    logic signed [EW-1:0] e_reg [6];
    logic signed [EW-1:0] e_next [6];
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [MW-1:0]        m_reg, m_next;
    logic [MW-1:0]        sum_reg, sum_next;
    logic [MW-1:0]        srem_reg, srem_next;
    logic [RW-1:0]        root_reg, root_next;
    logic [RW-1:0]        bit_reg, bit_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        dsh_reg, dsh_next;
    logic [QW-1:0]        q_reg, q_next;
    gvn_pkg::nrm_t        norm_reg [3];
    gvn_pkg::nrm_t        norm_next [3];

    logic signed [EW-1:0] mul_a, mul_b;
    logic [63:0]          sub_a, sub_b, sub_diff;
    logic                 sub_ge;
    logic [DIFF_MAG_W-1:0] dmag [6];
    localparam int DIFF_MAG_W = 33;
    logic [31:0]          dor;
    logic [1:0]           dsh_amt;
    logic [MW-1:0]        nmag [3];
    logic [MW-1:0]        nor_all;
    logic [QW:0]          qcap;

    // shared trial subtractor: square root and division steps
    always_comb
    begin
        if (state_reg == gvn_pkg::CS_DIV)
        begin
            sub_a = 64'(rem_reg);
            sub_b = 64'(dsh_reg);
        end
        else
        begin
            sub_a = 64'(srem_reg);
            sub_b = 64'(root_reg) + 64'(bit_reg);
        end
        sub_diff = sub_a - sub_b;
        sub_ge   = (sub_a >= sub_b);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == gvn_pkg::CS_SQ)
        begin
            case (step_reg)
                5'd0:    begin mul_a = n_reg[0][EW-1:0]; mul_b = n_reg[0][EW-1:0]; end
                5'd1:    begin mul_a = n_reg[1][EW-1:0]; mul_b = n_reg[1][EW-1:0]; end
                5'd2:    begin mul_a = n_reg[2][EW-1:0]; mul_b = n_reg[2][EW-1:0]; end
                default: ;
            endcase
        end
        else
        begin
            case (step_reg)
                5'd0:    begin mul_a = e_reg[1]; mul_b = e_reg[5]; end
                5'd1:    begin mul_a = e_reg[2]; mul_b = e_reg[4]; end
                5'd2:    begin mul_a = e_reg[2]; mul_b = e_reg[3]; end
                5'd3:    begin mul_a = e_reg[0]; mul_b = e_reg[5]; end
                5'd4:    begin mul_a = e_reg[0]; mul_b = e_reg[4]; end
                5'd5:    begin mul_a = e_reg[1]; mul_b = e_reg[3]; end
                default: ;
            endcase
        end
    end

    // input prescale and component magnitudes
    always_comb
    begin
        dor = '0;
        for (int i = 0; i < 6; i++)
        begin
            dmag[i] = d[i][DIFF_MAG_W-1] ? DIFF_MAG_W'(-d[i]) : DIFF_MAG_W'(d[i]);
            dor     = dor | dmag[i][31:0];
        end
        dsh_amt = dor[31] ? 2'd2 : (dor[30] ? 2'd1 : 2'd0);
        nor_all = '0;
        for (int j = 0; j < 3; j++)
        begin
            nmag[j] = n_reg[j][NW-1] ? MW'(-n_reg[j]) : MW'(n_reg[j]);
            nor_all = nor_all | nmag[j];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        e_next     = e_reg;
        n_next     = n_reg;
        prod_next  = PW'(mul_a * mul_b);
        m_next     = m_reg;
        sum_next   = sum_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        norm_next  = norm_reg;
        qcap       = '0;

        unique case (state_reg)
            gvn_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 6; i++)
                        e_next[i] = EW'(d[i] >>> dsh_amt);
                    step_next  = '0;
                    state_next = gvn_pkg::CS_MUL;
                end
            end
            gvn_pkg::CS_MUL:
            begin
                case (step_reg)
                    5'd1:    n_next[0] = NW'(prod_reg);
                    5'd2:    n_next[0] = n_reg[0] - NW'(prod_reg);
                    5'd3:    n_next[1] = NW'(prod_reg);
                    5'd4:    n_next[1] = n_reg[1] - NW'(prod_reg);
                    5'd5:    n_next[2] = NW'(prod_reg);
                    5'd6:    n_next[2] = n_reg[2] - NW'(prod_reg);
                    default: ;
                endcase
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd6)
                    state_next = gvn_pkg::CS_MAX;
            end
            gvn_pkg::CS_MAX:
            begin
                m_next = nor_all;
                if (nor_all == '0)
                begin
                    for (int j = 0; j < 3; j++)
                        norm_next[j] = '0;
                    state_next = gvn_pkg::CS_DONE;
                end
                else if (nor_all[MW-1:30] != '0)
                    state_next = gvn_pkg::CS_NORM_R;
                else
                    state_next = gvn_pkg::CS_NORM_L;
            end
            gvn_pkg::CS_NORM_R:
            begin
                // floor shifts compose, so coarse steps are exact
                if (m_reg[MW-1:34] != '0)
                begin
                    for (int j = 0; j < 3; j++)
                        n_next[j] = n_reg[j] >>> 4;
                    m_next = m_reg >> 4;
                end
                else if (m_reg[MW-1:30] != '0)
                begin
                    for (int j = 0; j < 3; j++)
                        n_next[j] = n_reg[j] >>> 1;
                    m_next = m_reg >> 1;
                end
                else
                begin
                    step_next  = '0;
                    sum_next   = '0;
                    state_next = gvn_pkg::CS_SQ;
                end
            end
            gvn_pkg::CS_NORM_L:
            begin
                if (m_reg[29:25] == '0)
                begin
                    for (int j = 0; j < 3; j++)
                        n_next[j] = n_reg[j] <<< 4;
                    m_next = m_reg << 4;
                end
                else if (!m_reg[29])
                begin
                    for (int j = 0; j < 3; j++)
                        n_next[j] = n_reg[j] <<< 1;
                    m_next = m_reg << 1;
                end
                else
                begin
                    step_next  = '0;
                    sum_next   = '0;
                    state_next = gvn_pkg::CS_SQ;
                end
            end
            gvn_pkg::CS_SQ:
            begin
                if (step_reg != 5'd0)
                    sum_next = sum_reg + MW'(prod_reg);
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    srem_next  = sum_next;
                    root_next  = '0;
                    bit_next   = RW'(1) << (RW - 1);
                    step_next  = '0;
                    state_next = gvn_pkg::CS_SQRT;
                end
            end
            gvn_pkg::CS_SQRT:
            begin
                if (sub_ge)
                begin
                    srem_next = sub_diff[MW-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    len_next   = (root_next[LW-1:0] == '0) ? LW'(1) : root_next[LW-1:0];
                    comp_next  = '0;
                    state_next = gvn_pkg::CS_DIV_LD;
                end
            end
            gvn_pkg::CS_DIV_LD:
            begin
                rem_next   = {nmag[comp_reg][30:0], 14'b0} + DW'(len_reg >> 1);
                dsh_next   = {len_reg, 14'b0};
                q_next     = '0;
                step_next  = '0;
                state_next = gvn_pkg::CS_DIV;
            end
            gvn_pkg::CS_DIV:
            begin
                if (sub_ge)
                    rem_next = sub_diff[DW-1:0];
                q_next    = {q_reg[QW-2:0], sub_ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd14)
                begin
                    qcap = (q_next > QW'(gvn_pkg::Q14_ONE)) ?
                           (QW+1)'(gvn_pkg::Q14_ONE) : (QW+1)'(q_next);
                    norm_next[comp_reg] = n_reg[comp_reg][NW-1] ?
                                          -gvn_pkg::nrm_t'(qcap) : gvn_pkg::nrm_t'(qcap);
                    if (comp_reg == 2'd2)
                        state_next = gvn_pkg::CS_DONE;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = gvn_pkg::CS_DIV_LD;
                    end
                end
            end
            gvn_pkg::CS_DONE:
                state_next = gvn_pkg::CS_IDLE;
            default:
                state_next = gvn_pkg::CS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gvn_pkg::CS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        comp_reg <= comp_next;
        e_reg    <= e_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
        m_reg    <= m_next;
        sum_reg  <= sum_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        norm_reg <= norm_next;
    end

    assign done = (state_reg == gvn_pkg::CS_DONE);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            norm[j] = norm_reg[j];
    end

endmodule
